### hw/rtl/lcac_pkg.sv
// Package for the line charset autodetect converter.
// Holds the sizes, view codes, character table, view functions, state type and run status.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package lcac_pkg;

	localparam int WINDOW    = 64;
	localparam int NUM_VIEWS = 5;
	localparam int AW        = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int CW        = $clog2(WINDOW + 1);
	localparam int SW        = CW + 1;

	localparam logic [7:0] NEWLINE_CHAR = 8'h0a;
	localparam logic [7:0] DOT_CHAR     = 8'h2e;

	localparam logic [2:0] CODE_ASCII   = 3'd0;
	localparam logic [2:0] CODE_EBCDIC  = 3'd1;
	localparam logic [2:0] CODE_ASCII2  = 3'd2;
	localparam logic [2:0] CODE_EBCDIC2 = 3'd3;
	localparam logic [2:0] CODE_INVALID = 3'd4;
	localparam logic [2:0] CODE_NONE    = 3'd7;

	localparam logic [7:0] A2E_ROM [256] = '{
		8'h00, 8'h01, 8'h02, 8'h03, 8'h37, 8'h2d, 8'h2e, 8'h2f, 8'h16, 8'h05, 8'h15, 8'h0b,
		8'h0c, 8'h0d, 8'h0e, 8'h0f, 8'h10, 8'h11, 8'h12, 8'h13, 8'h3c, 8'h3d, 8'h32, 8'h26,
		8'h18, 8'h19, 8'h3f, 8'h27, 8'h1c, 8'h1d, 8'h1e, 8'h1f, 8'h40, 8'h5a, 8'h7f, 8'h7b,
		8'h5b, 8'h6c, 8'h50, 8'h7d, 8'h4d, 8'h5d, 8'h5c, 8'h4e, 8'h6b, 8'h60, 8'h4b, 8'h61,
		8'hf0, 8'hf1, 8'hf2, 8'hf3, 8'hf4, 8'hf5, 8'hf6, 8'hf7, 8'hf8, 8'hf9, 8'h7a, 8'h5e,
		8'h4c, 8'h7e, 8'h6e, 8'h6f, 8'h7c, 8'hc1, 8'hc2, 8'hc3, 8'hc4, 8'hc5, 8'hc6, 8'hc7,
		8'hc8, 8'hc9, 8'hd1, 8'hd2, 8'hd3, 8'hd4, 8'hd5, 8'hd6, 8'hd7, 8'hd8, 8'hd9, 8'he2,
		8'he3, 8'he4, 8'he5, 8'he6, 8'he7, 8'he8, 8'he9, 8'had, 8'he0, 8'hbd, 8'h5f, 8'h6d,
		8'h79, 8'h81, 8'h82, 8'h83, 8'h84, 8'h85, 8'h86, 8'h87, 8'h88, 8'h89, 8'h91, 8'h92,
		8'h93, 8'h94, 8'h95, 8'h96, 8'h97, 8'h98, 8'h99, 8'ha2, 8'ha3, 8'ha4, 8'ha5, 8'ha6,
		8'ha7, 8'ha8, 8'ha9, 8'hc0, 8'h4f, 8'hd0, 8'ha1, 8'h07, 8'h20, 8'h21, 8'h22, 8'h23,
		8'h24, 8'h25, 8'h06, 8'h17, 8'h28, 8'h29, 8'h2a, 8'h2b, 8'h2c, 8'h09, 8'h0a, 8'h1b,
		8'h30, 8'h31, 8'h1a, 8'h33, 8'h34, 8'h35, 8'h36, 8'h08, 8'h38, 8'h39, 8'h3a, 8'h3b,
		8'h04, 8'h14, 8'h3e, 8'hff, 8'h41, 8'haa, 8'h4a, 8'hb1, 8'h9f, 8'hb2, 8'h6a, 8'hb5,
		8'hbb, 8'hb4, 8'h9a, 8'h8a, 8'hb0, 8'hca, 8'haf, 8'hbc, 8'h90, 8'h8f, 8'hea, 8'hfa,
		8'hbe, 8'ha0, 8'hb6, 8'hb3, 8'h9d, 8'hda, 8'h9b, 8'h8b, 8'hb7, 8'hb8, 8'hb9, 8'hab,
		8'h64, 8'h65, 8'h62, 8'h66, 8'h63, 8'h67, 8'h9e, 8'h68, 8'h74, 8'h71, 8'h72, 8'h73,
		8'h78, 8'h75, 8'h76, 8'h77, 8'hac, 8'h69, 8'hed, 8'hee, 8'heb, 8'hef, 8'hec, 8'hbf,
		8'h80, 8'hfd, 8'hfe, 8'hfb, 8'hfc, 8'hba, 8'hae, 8'h59, 8'h44, 8'h45, 8'h42, 8'h46,
		8'h43, 8'h47, 8'h9c, 8'h48, 8'h54, 8'h51, 8'h52, 8'h53, 8'h58, 8'h55, 8'h56, 8'h57,
		8'h8c, 8'h49, 8'hcd, 8'hce, 8'hcb, 8'hcf, 8'hcc, 8'he1, 8'h70, 8'hdd, 8'hde, 8'hdb,
		8'hdc, 8'h8d, 8'h8e, 8'hdf
	};

	typedef enum logic [2:0] {
		ST_IDLE, ST_SCAN_RD, ST_SCAN_EV, ST_DECIDE, ST_PUSH, ST_EM_RD, ST_EM_EV
	} state_t;

	typedef struct packed {
		logic [NUM_VIEWS-1:0][CW-1:0] len;
		logic [NUM_VIEWS-1:0]         nl;
		logic [NUM_VIEWS-1:0]         ended;
		logic                         all_ended;
		logic [2:0]                   best_code;
		logic [CW-1:0]                best_len;
	} run_stat_t;

	function automatic logic [7:0] a2e(input logic [7:0] b);
		return A2E_ROM[b];
	endfunction

	// Inverse table; values never produced by the forward table give zero.
	function automatic logic [7:0] e2a(input logic [7:0] b);
		logic [7:0] r;
		r = 8'h00;
		for (int i = 0; i < 256; i++) begin
			if (A2E_ROM[i] == b) r = 8'(i);
		end
		return r;
	endfunction

	function automatic logic printable(input logic [7:0] c);
		return ((c >= 8'h20) && (c <= 8'h7e)) || ((c >= 8'h07) && (c <= 8'h0d));
	endfunction

	function automatic logic [2:0] view_code(input int slot);
		return (slot + 1 < NUM_VIEWS) ? 3'(slot) : CODE_INVALID;
	endfunction

	// One of the four translating views; zero where the result is unprintable.
	function automatic logic [7:0] base_char(input logic [2:0] code, input logic [7:0] b);
		logic [7:0] c;
		case (code)
			CODE_ASCII:   c = b;
			CODE_EBCDIC:  c = e2a(b);
			CODE_ASCII2:  c = a2e(b);
			CODE_EBCDIC2: c = e2a(e2a(b));
			default:      c = 8'h00;
		endcase
		return printable(c) ? c : 8'h00;
	endfunction

	function automatic logic [7:0] view_char(input logic [2:0] code, input logic [7:0] b);
		logic any;
		any = 1'b0;
		if (code == CODE_INVALID) begin
			for (int v = 0; (v + 1 < NUM_VIEWS) && (v < 4); v++) begin
				any = any | (base_char(3'(v), b) != 8'h00);
			end
			return any ? 8'h00 : DOT_CHAR;
		end
		return base_char(code, b);
	endfunction

	function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
		input logic [CW-1:0] off);
		logic [SW-1:0] s;
		s = SW'(base) + SW'(off);
		if (s >= SW'(WINDOW)) s = s - SW'(WINDOW);
		return AW'(s);
	endfunction

endpackage
`default_nettype wire

### hw/rtl/lcac_if.sv
// Stream interfaces for the converter's input and result channels.
// Depends on nothing but the byte and code widths.
`timescale 1ns / 1ps
`default_nettype none
interface lcac_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       end_of_stream;
	modport source (output valid, output in_byte, output end_of_stream, input ready);
	modport sink (input valid, input in_byte, input end_of_stream, output ready);
endinterface

interface lcac_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic [2:0] choice;
	logic       segment_end;
	logic       last;
	modport source (output valid, output out_byte, output choice, output segment_end,
		output last, input ready);
	modport sink (input valid, input out_byte, input choice, input segment_end,
		input last, output ready);
endinterface
`default_nettype wire

### hw/rtl/lcac_runs.sv
// Per-view run measurement lanes and the winner selection.
// Depends on lcac_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lcac_runs (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                clear,
	input  wire logic                step,
	input  wire logic [7:0]          byte_in,
	input  wire logic [2:0]          prev_code,
	output lcac_pkg::run_stat_t      stat
);
	logic [lcac_pkg::NUM_VIEWS-1:0][lcac_pkg::CW-1:0] len_q;
	logic [lcac_pkg::NUM_VIEWS-1:0] nl_q;
	logic [lcac_pkg::NUM_VIEWS-1:0] ended_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= '0;
			nl_q    <= '0;
			ended_q <= '0;
		end else if (clear) begin
			len_q   <= '0;
			nl_q    <= '0;
			ended_q <= '0;
		end else if (step) begin
			for (int s = 0; s < lcac_pkg::NUM_VIEWS; s++) begin
				if (!ended_q[s]) begin
					if (lcac_pkg::view_char(lcac_pkg::view_code(s), byte_in) == 8'h00) begin
						ended_q[s] <= 1'b1;
					end else begin
						len_q[s] <= len_q[s] + 1'b1;
						if (lcac_pkg::view_char(lcac_pkg::view_code(s), byte_in) ==
							lcac_pkg::NEWLINE_CHAR) begin
							ended_q[s] <= 1'b1;
							nl_q[s]    <= 1'b1;
						end
					end
				end
			end
		end
	end

	// Longest run wins; an equal run wins only if it was the previous choice.
	// The search stops at the first view that wins, longer or tied as previous choice, whose run ends in a newline.
	always_comb begin
		logic [lcac_pkg::CW-1:0] mx;
		logic [2:0]              bc;
		logic                    stop;
		mx   = '0;
		bc   = lcac_pkg::view_code(0);
		stop = 1'b0;
		for (int s = 0; s < lcac_pkg::NUM_VIEWS; s++) begin
			if (!stop) begin
				if (len_q[s] > mx) begin
					mx   = len_q[s];
					bc   = lcac_pkg::view_code(s);
					stop = nl_q[s];
				end else if (len_q[s] == mx && lcac_pkg::view_code(s) == prev_code) begin
					bc   = lcac_pkg::view_code(s);
					stop = nl_q[s];
				end
			end
		end
		stat.len       = len_q;
		stat.nl        = nl_q;
		stat.ended     = ended_q;
		stat.all_ended = &ended_q;
		stat.best_code = bc;
		stat.best_len  = mx;
	end
endmodule
`default_nettype wire

### hw/rtl/line_charset_autodetect_converter_top.sv
// Top level of the line charset autodetect converter: window memory, sequencer, output stage.
// Depends on lcac_pkg, lcac_if and lcac_runs.
// A beat is stored into the window; every scan then reads the window byte by byte through the
// single registered window read port, with a read and an evaluate state per byte, a closing read
// state and a decision state; each emitted byte passes a read and an evaluate state, each held run
// end a push state, both waiting while the result channel is busy; beats are taken only in idle.
// Reset clears the fill count, the window pointer, the previous choice (to none) and the
// output flag; the window memory itself is not cleared and needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module line_charset_autodetect_converter_top (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  cfg_we,
	input  wire logic  cfg_wdata,
	lcac_in_if.sink    in_ch,
	lcac_out_if.source out_ch
);
	// The window is a circular buffer: head_q marks its first byte, so removing an
	// emitted run only moves the head instead of shifting the data.
	logic [7:0] mem [lcac_pkg::WINDOW];
	logic [7:0] rdata_q;

	lcac_pkg::state_t state_q, state_d;
	logic [lcac_pkg::AW-1:0] head_q;
	logic [lcac_pkg::CW-1:0] fill_q;
	logic [lcac_pkg::CW-1:0] idx_q;
	logic [lcac_pkg::CW-1:0] max_q;
	logic [2:0] code_q;
	logic [2:0] prev_q;
	logic       eos_q;
	logic       fin_q;
	logic       oebc_q;

	// The final beat of a run waits here until the next decision tells whether it is
	// the last result of the item.
	logic       pend_v_q;
	logic [7:0] pend_byte_q;
	logic [2:0] pend_code_q;

	logic       out_v_q;
	logic [7:0] out_byte_q;
	logic [2:0] out_code_q;
	logic       out_seg_q;
	logic       out_last_q;

	lcac_pkg::run_stat_t stat;

	logic accept, out_free, decide, is_final;
	logic lane_clear, lane_step, load_beat;
	logic [7:0] view_byte, emit_byte;

	assign accept   = in_ch.valid && in_ch.ready;
	assign out_free = !out_v_q || out_ch.ready;
	assign decide   = (fill_q != '0) &&
		(stat.all_ended || fill_q == lcac_pkg::CW'(lcac_pkg::WINDOW) || eos_q);
	assign is_final  = (idx_q + 1'b1) == max_q;
	assign view_byte = lcac_pkg::view_char(code_q, rdata_q);
	assign emit_byte = oebc_q ? lcac_pkg::a2e(view_byte) : view_byte;

	lcac_runs u_runs (
		.clk       (clk),
		.arst_n    (arst_n),
		.clear     (lane_clear),
		.step      (lane_step),
		.byte_in   (rdata_q),
		.prev_code (prev_q),
		.stat      (stat)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			mem[lcac_pkg::wrap_add(head_q, fill_q)] <= in_ch.in_byte;
		end
		rdata_q <= mem[lcac_pkg::wrap_add(head_q, idx_q)];
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lcac_pkg::ST_IDLE: begin
				if (accept) state_d = lcac_pkg::ST_SCAN_RD;
			end
			lcac_pkg::ST_SCAN_RD: begin
				if (idx_q == fill_q || stat.all_ended) state_d = lcac_pkg::ST_DECIDE;
				else state_d = lcac_pkg::ST_SCAN_EV;
			end
			lcac_pkg::ST_SCAN_EV: state_d = lcac_pkg::ST_SCAN_RD;
			lcac_pkg::ST_DECIDE: begin
				if (pend_v_q) state_d = lcac_pkg::ST_PUSH;
				else if (decide) state_d = lcac_pkg::ST_EM_RD;
				else state_d = lcac_pkg::ST_IDLE;
			end
			lcac_pkg::ST_PUSH: begin
				if (out_free) state_d = fin_q ? lcac_pkg::ST_IDLE : lcac_pkg::ST_EM_RD;
			end
			lcac_pkg::ST_EM_RD: state_d = lcac_pkg::ST_EM_EV;
			lcac_pkg::ST_EM_EV: begin
				if (is_final) state_d = lcac_pkg::ST_SCAN_RD;
				else if (out_free) state_d = lcac_pkg::ST_EM_RD;
			end
			default: state_d = lcac_pkg::ST_IDLE;
		endcase
	end

	// Control outputs. In idle the input is always ready, so a valid beat is accepted.
	always_comb begin
		in_ch.ready = 1'b0;
		lane_clear  = 1'b0;
		lane_step   = 1'b0;
		load_beat   = 1'b0;
		unique case (state_q)
			lcac_pkg::ST_IDLE: begin
				in_ch.ready = 1'b1;
				lane_clear  = in_ch.valid;
			end
			lcac_pkg::ST_SCAN_EV: lane_step = 1'b1;
			lcac_pkg::ST_PUSH: load_beat = out_free;
			lcac_pkg::ST_EM_EV: begin
				lane_clear = is_final;
				load_beat  = !is_final && out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= lcac_pkg::ST_IDLE;
			head_q   <= '0;
			fill_q   <= '0;
			idx_q    <= '0;
			max_q    <= '0;
			code_q   <= lcac_pkg::CODE_ASCII;
			prev_q   <= lcac_pkg::CODE_NONE;
			eos_q    <= 1'b0;
			fin_q    <= 1'b0;
			oebc_q   <= 1'b0;
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) oebc_q <= cfg_wdata;
			if (load_beat) out_v_q <= 1'b1;
			else if (out_ch.ready) out_v_q <= 1'b0;
			if (lane_clear) idx_q <= '0;
			unique case (state_q)
				lcac_pkg::ST_IDLE: begin
					if (accept) begin
						fill_q <= fill_q + 1'b1;
						eos_q  <= in_ch.end_of_stream;
					end
				end
				lcac_pkg::ST_SCAN_EV: idx_q <= idx_q + 1'b1;
				lcac_pkg::ST_DECIDE: begin
					idx_q <= '0;
					fin_q <= !decide;
					if (decide) begin
						code_q <= stat.best_code;
						max_q  <= stat.best_len;
						prev_q <= stat.best_code;
					end
				end
				lcac_pkg::ST_PUSH: begin
					if (out_free) pend_v_q <= 1'b0;
				end
				lcac_pkg::ST_EM_EV: begin
					if (is_final) begin
						pend_v_q <= 1'b1;
						head_q   <= lcac_pkg::wrap_add(head_q, max_q);
						fill_q   <= fill_q - max_q;
					end else if (out_free) begin
						idx_q <= idx_q + 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (state_q == lcac_pkg::ST_EM_EV && is_final) begin
			pend_byte_q <= emit_byte;
			pend_code_q <= code_q;
		end
		if (load_beat) begin
			if (state_q == lcac_pkg::ST_PUSH) begin
				out_byte_q <= pend_byte_q;
				out_code_q <= pend_code_q;
				out_seg_q  <= 1'b1;
				out_last_q <= fin_q;
			end else begin
				out_byte_q <= emit_byte;
				out_code_q <= code_q;
				out_seg_q  <= 1'b0;
				out_last_q <= 1'b0;
			end
		end
	end

	assign out_ch.valid       = out_v_q;
	assign out_ch.out_byte    = out_byte_q;
	assign out_ch.choice      = out_code_q;
	assign out_ch.segment_end = out_seg_q;
	assign out_ch.last        = out_last_q;

	// The window never holds more than its capacity.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= lcac_pkg::CW'(lcac_pkg::WINDOW))
		else $error("window fill count beyond capacity");

	// No run beat may be left waiting once the block is idle again.
	a_idle_no_pend: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == lcac_pkg::ST_IDLE |-> !pend_v_q)
		else $error("held run end left behind at idle");

	// An accepted beat always starts a scan.
	a_accept_scan: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == lcac_pkg::ST_SCAN_RD && idx_q == '0)
		else $error("accepted beat did not start a scan");

	// Emission stays inside the chosen run, which fits in the window.
	a_emit_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lcac_pkg::ST_EM_RD || state_q == lcac_pkg::ST_EM_EV) |->
		(idx_q < max_q && max_q <= fill_q))
		else $error("emission index outside the chosen run");
endmodule
`default_nettype wire
